// ----- rtl/core/dtr_pkg.sv -----
// shared types, constants and microcode rom for the divider timer block
// no dependencies
`default_nettype none

package dtr_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DivW   = 16;
  localparam int unsigned PhaseW = 10;
  localparam int unsigned LenW   = 4;
  localparam int unsigned StepW  = 3;

  typedef logic [StepW-1:0] step_t;

  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_WRITE = 2'd2;
  localparam logic [FuncW-1:0] FUNC_NONE  = 2'd3;

  localparam logic [AddrW-1:0] ADDR_DIV   = 16'hFF04;
  localparam logic [AddrW-1:0] ADDR_TIMA  = 16'hFF05;
  localparam logic [AddrW-1:0] ADDR_TMA   = 16'hFF06;
  localparam logic [AddrW-1:0] ADDR_TAC   = 16'hFF07;
  localparam logic [AddrW-1:0] ADDR_IF    = 16'hFF0F;

  localparam logic [LenW-1:0]   CHUNK_MAX   = 4'd10;
  localparam logic [ByteW-1:0]  CTRL_HIGH   = 8'hF8;
  localparam logic [ByteW-1:0]  FLAGS_HIGH  = 8'hE0;
  localparam logic [ByteW-1:0]  UNMAPPED    = 8'hFF;
  localparam int unsigned       CTRL_EN_BIT = 2;
  localparam int unsigned       IRQ_BIT     = 2;

  localparam logic [PhaseW-1:0] MASK_1023 = 10'd1023;
  localparam logic [PhaseW-1:0] MASK_15   = 10'd15;
  localparam logic [PhaseW-1:0] MASK_63   = 10'd63;
  localparam logic [PhaseW-1:0] MASK_255  = 10'd255;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK_INIT,
    OP_CHUNK,
    OP_READ,
    OP_WRITE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_DISPATCH,
    C_AMT_ZERO,
    C_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam step_t S_FETCH    = 3'd0;
  localparam step_t S_DISPATCH = 3'd1;
  localparam step_t S_TICK     = 3'd2;
  localparam step_t S_CHUNK    = 3'd3;
  localparam step_t S_EMIT     = 3'd4;
  localparam step_t S_READ     = 3'd5;
  localparam step_t S_WRITE    = 3'd6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } uword_t;

  typedef struct packed {
    logic             in_valid;
    logic [FuncW-1:0] func;
    logic             amt_zero;
    logic             more;
    logic             out_busy;
  } status_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    unique case (pc)
      S_FETCH:    w = '{OP_LATCH,     C_NO_INPUT, S_FETCH, S_DISPATCH};
      S_DISPATCH: w = '{OP_NONE,      C_DISPATCH, S_FETCH, S_FETCH};
      S_TICK:     w = '{OP_TICK_INIT, C_AMT_ZERO, S_EMIT,  S_CHUNK};
      S_CHUNK:    w = '{OP_CHUNK,     C_MORE,     S_CHUNK, S_EMIT};
      S_EMIT:     w = '{OP_EMIT,      C_OUT_BUSY, S_EMIT,  S_FETCH};
      S_READ:     w = '{OP_READ,      C_ALWAYS,   S_EMIT,  S_EMIT};
      S_WRITE:    w = '{OP_WRITE,     C_ALWAYS,   S_EMIT,  S_EMIT};
      default:    w = '{OP_NONE,      C_ALWAYS,   S_FETCH, S_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dtr_if.sv -----
// valid/ready channel interfaces for request and response transactions
// depends on dtr_pkg
`default_nettype none

interface dtr_in_if;
  import dtr_pkg::*;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [AddrW-1:0] bus_address;
  logic [ByteW-1:0] write_data;
  logic [ByteW-1:0] cycle_amount;
  modport source (output valid, func, bus_address, write_data, cycle_amount, input ready);
  modport sink (input valid, func, bus_address, write_data, cycle_amount, output ready);
endinterface

interface dtr_out_if;
  import dtr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic [ByteW-1:0] interrupt_flags;
  modport source (output valid, read_data, interrupt_flags, input ready);
  modport sink (input valid, read_data, interrupt_flags, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/divider_timer_with_reload.sv -----
// top level of the divider timer with counter reload
// depends on dtr_pkg, dtr_if, dtr_useq and dtr_dpath
`default_nettype none

// Divider/timer peripheral driven by a seven-step microprogram. Each request
// transaction yields exactly one response transaction carrying the read byte
// and the interrupt flag byte after the operation. Reads, writes and zero-length
// ticks pass through the fetch, dispatch, operation and emit steps; a tick of
// nonzero amount also runs the chunk step before emit, stepping the timer counter
// one chunk of up to 10 of the amount per clock. A new request is taken only in
// the fetch step; the response register lets the next request enter while a
// response still waits.

module divider_timer_with_reload (
  input wire logic  clk,
  input wire logic  rst,
  dtr_in_if.sink    req,
  dtr_out_if.source rsp
);
  import dtr_pkg::*;

  uword_t  uword;
  status_t status;

  dtr_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  dtr_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .uword  (uword),
    .status (status),
    .req    (req),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dtr_useq.sv -----
// microcode sequencer: step counter, control rom and jump logic
// depends on dtr_pkg
`default_nettype none

module dtr_useq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  dtr_pkg::status_t      status,
  output dtr_pkg::uword_t       uword
);
  import dtr_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  take;

  assign uword = ucode(pc);

  always_comb begin
    unique case (uword.cond)
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !status.in_valid;
      C_DISPATCH: take = 1'b1;
      C_AMT_ZERO: take = status.amt_zero;
      C_MORE:     take = status.more;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    if (uword.cond == C_DISPATCH) begin
      unique case (status.func)
        FUNC_TICK:  pc_next = S_TICK;
        FUNC_READ:  pc_next = S_READ;
        FUNC_WRITE: pc_next = S_WRITE;
        FUNC_NONE:  pc_next = S_EMIT;
        default:    pc_next = S_EMIT;
      endcase
    end else begin
      pc_next = take ? uword.tgt_true : uword.tgt_false;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dtr_dpath.sv -----
// datapath: timer registers, chunk step unit, bus access and response register
// depends on dtr_pkg and dtr_if
`default_nettype none

module dtr_dpath (
  input  wire logic        clk,
  input  wire logic        rst,
  input  dtr_pkg::uword_t  uword,
  output dtr_pkg::status_t status,
  dtr_in_if.sink           req,
  dtr_out_if.source        rsp
);
  import dtr_pkg::*;

  logic [DivW-1:0]   divider;
  logic [ByteW-1:0]  timer_count;
  logic [ByteW-1:0]  timer_reload;
  logic [ByteW-1:0]  timer_control;
  logic [ByteW-1:0]  irq_flags;
  logic              irq_delayed;

  logic [FuncW-1:0]  func;
  logic [AddrW-1:0]  addr;
  logic [ByteW-1:0]  wdata;
  logic [ByteW-1:0]  amount;
  logic [ByteW-1:0]  left;
  logic [PhaseW-1:0] phase;
  logic [ByteW-1:0]  rdata;

  logic              out_valid;
  logic [ByteW-1:0]  out_rdata;
  logic [ByteW-1:0]  out_flags;

  logic [LenW-1:0]   len;
  logic [PhaseW-1:0] mask;
  logic [PhaseW:0]   phase_sum;
  logic              step;
  logic [ByteW-1:0]  rd_mux;
  logic              accept;

  assign req.ready = (uword.op == OP_LATCH);
  assign accept    = req.valid && req.ready;

  assign rsp.valid           = out_valid;
  assign rsp.read_data       = out_rdata;
  assign rsp.interrupt_flags = out_flags;

  assign status.in_valid = req.valid;
  assign status.func     = func;
  assign status.amt_zero = (amount == '0);
  assign status.more     = (left > ByteW'(CHUNK_MAX));
  assign status.out_busy = out_valid && !rsp.ready;

  // chunk length and divider carry test
  always_comb begin
    len = (left >= ByteW'(CHUNK_MAX)) ? CHUNK_MAX : left[LenW-1:0];
    unique case (timer_control[1:0])
      2'd0:    mask = MASK_1023;
      2'd1:    mask = MASK_15;
      2'd2:    mask = MASK_63;
      2'd3:    mask = MASK_255;
      default: mask = MASK_1023;
    endcase
    phase_sum = {1'b0, phase & mask} + {1'b0, PhaseW'(len) & mask};
    step      = timer_control[CTRL_EN_BIT] && (phase_sum > {1'b0, mask});
  end

  always_comb begin
    unique case (addr)
      ADDR_DIV:  rd_mux = divider[DivW-1 -: ByteW];
      ADDR_TIMA: rd_mux = timer_count;
      ADDR_TMA:  rd_mux = timer_reload;
      ADDR_TAC:  rd_mux = timer_control | CTRL_HIGH;
      ADDR_IF:   rd_mux = irq_flags | FLAGS_HIGH;
      default:   rd_mux = UNMAPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider       <= '0;
      timer_count   <= '0;
      timer_reload  <= '0;
      timer_control <= '0;
      irq_flags     <= '0;
      irq_delayed   <= 1'b0;
      func          <= FUNC_NONE;
      amount        <= '0;
      left          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (uword.op)
        OP_LATCH: begin
          if (accept) begin
            func   <= req.func;
            amount <= req.cycle_amount;
          end
        end
        OP_TICK_INIT: begin
          divider <= divider + DivW'(amount);
          left    <= amount;
        end
        OP_CHUNK: begin
          left <= left - ByteW'(len);
          if (irq_delayed) begin
            irq_flags[IRQ_BIT] <= 1'b1;
          end
          irq_delayed <= 1'b0;
          if (step) begin
            if (timer_count == '1) begin
              timer_count <= timer_reload;
              irq_delayed <= 1'b1;
            end else begin
              timer_count <= timer_count + ByteW'(1);
            end
          end
        end
        OP_WRITE: begin
          unique case (addr)
            ADDR_DIV:  divider       <= '0;
            ADDR_TIMA: timer_count   <= wdata;
            ADDR_TMA:  timer_reload  <= wdata;
            ADDR_TAC:  timer_control <= wdata;
            ADDR_IF:   irq_flags     <= wdata;
            default:   ;
          endcase
        end
        OP_EMIT: begin
          if (!status.out_busy) begin
            out_valid <= 1'b1;
          end
        end
        OP_NONE, OP_READ: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (uword.op)
      OP_LATCH: begin
        rdata <= '0;
        if (accept) begin
          addr  <= req.bus_address;
          wdata <= req.write_data;
        end
      end
      OP_TICK_INIT: phase <= divider[PhaseW-1:0];
      OP_CHUNK:     phase <= phase + PhaseW'(len);
      OP_READ:      rdata <= rd_mux;
      OP_EMIT: begin
        if (!status.out_busy) begin
          out_rdata <= rdata;
          out_flags <= irq_flags;
        end
      end
      OP_NONE, OP_WRITE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for divider_timer_with_reload: random and directed bus and tick transactions
// checked against an in-bench timer predictor; depends on dtr_pkg, dtr_if and the rtl top
`default_nettype none

module tb_top;
  import dtr_pkg::*;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
    logic [ByteW-1:0] amount;
  } timer_req_t;

  typedef struct packed {
    logic [ByteW-1:0] rdata;
    logic [ByteW-1:0] flags;
  } timer_rsp_t;

  logic clk;
  logic rst;

  dtr_in_if  req_bus ();
  dtr_out_if rsp_bus ();

  divider_timer_with_reload dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // predicted timer state
  logic [DivW-1:0]  div_cnt;
  logic [ByteW-1:0] tima;
  logic [ByteW-1:0] tma;
  logic [ByteW-1:0] tac;
  logic [ByteW-1:0] if_reg;
  logic [ByteW-1:0] irq_pending;

  timer_req_t pending_reqs[$];
  timer_rsp_t awaited_rsps[$];

  int total_reqs;
  int taken_reqs;
  int errors;
  int n_tick;
  int n_read;
  int n_write;
  int n_wrap;
  int n_rsp;

  logic       req_taken;
  logic       next_valid;
  int         send_gap;
  int         drv_calm;
  int         rcv_stall;
  int         rcv_calm;
  timer_req_t drv_item;
  timer_req_t seen_req;
  timer_rsp_t want_rsp;

  function automatic void run_timer_chunk(logic [DivW-1:0] start, logic [LenW-1:0] len);
    logic [PhaseW-1:0] mask;
    logic [PhaseW:0]   sum;
    if_reg = if_reg | irq_pending;
    irq_pending = '0;
    if (!tac[CTRL_EN_BIT]) return;
    case (tac[1:0])
      2'd0: mask = MASK_1023;
      2'd1: mask = MASK_15;
      2'd2: mask = MASK_63;
      default: mask = MASK_255;
    endcase
    sum = {1'b0, start[PhaseW-1:0] & mask} + {1'b0, {{(PhaseW-LenW){1'b0}}, len} & mask};
    if (sum > {1'b0, mask}) begin
      tima = tima + 8'd1;
      if (tima == '0) begin
        tima = tma;
        irq_pending[IRQ_BIT] = 1'b1;
        n_wrap++;
      end
    end
  endfunction

  function automatic timer_rsp_t next_timer_response(timer_req_t r);
    timer_rsp_t       res;
    logic [DivW-1:0]  start;
    logic [ByteW-1:0] left;
    logic [LenW-1:0]  len;
    res.rdata = '0;
    case (r.func)
      FUNC_TICK: begin
        n_tick++;
        start = div_cnt;
        left = r.amount;
        div_cnt = div_cnt + {8'd0, r.amount};
        while (left != '0) begin
          len = (left < {4'd0, CHUNK_MAX}) ? left[LenW-1:0] : CHUNK_MAX;
          run_timer_chunk(start, len);
          left = left - {4'd0, len};
          start = start + {12'd0, len};
        end
      end
      FUNC_READ: begin
        n_read++;
        case (r.addr)
          ADDR_DIV:  res.rdata = div_cnt[DivW-1:DivW-ByteW];
          ADDR_TIMA: res.rdata = tima;
          ADDR_TMA:  res.rdata = tma;
          ADDR_TAC:  res.rdata = tac | CTRL_HIGH;
          ADDR_IF:   res.rdata = if_reg | FLAGS_HIGH;
          default:   res.rdata = UNMAPPED;
        endcase
      end
      FUNC_WRITE: begin
        n_write++;
        case (r.addr)
          ADDR_DIV:  div_cnt = '0;
          ADDR_TIMA: tima = r.wdata;
          ADDR_TMA:  tma = r.wdata;
          ADDR_TAC:  tac = r.wdata;
          ADDR_IF:   if_reg = r.wdata;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.flags = if_reg;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1: return ADDR_DIV;
      2, 3: return ADDR_TIMA;
      4:    return ADDR_TMA;
      5, 6: return ADDR_TAC;
      7, 8: return ADDR_IF;
      default: return AddrW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_req(logic [FuncW-1:0] f, logic [AddrW-1:0] a, logic [ByteW-1:0] d,
                         logic [ByteW-1:0] amt);
    timer_req_t r;
    r.func = f;
    r.addr = a;
    r.wdata = d;
    r.amount = amt;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  task automatic add_random_req();
    int               r;
    logic [AddrW-1:0] a;
    logic [ByteW-1:0] d;
    r = $urandom_range(0, 99);
    a = pick_addr();
    d = ByteW'($urandom_range(0, 255));
    if (r < 50) begin
      case ($urandom_range(0, 9))
        0:       add_req(FUNC_TICK, a, d, ByteW'($urandom_range(0, 255)));
        1:       add_req(FUNC_TICK, a, d, ByteW'($urandom_range(0, 3)));
        default: add_req(FUNC_TICK, a, d, ByteW'($urandom_range(4, 24)));
      endcase
    end else if (r < 75) begin
      if (a == ADDR_TIMA && $urandom_range(0, 1)) d = ByteW'($urandom_range(240, 255));
      if (a == ADDR_TMA && $urandom_range(0, 1)) d = ByteW'($urandom_range(224, 255));
      if (a == ADDR_TAC && $urandom_range(0, 3) != 0) d[CTRL_EN_BIT] = 1'b1;
      add_req(FUNC_WRITE, a, d, ByteW'($urandom_range(0, 255)));
    end else if (r < 95) begin
      add_req(FUNC_READ, a, d, ByteW'($urandom_range(0, 255)));
    end else begin
      add_req(FUNC_NONE, a, d, ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 800000);
    $display("CHECK FAILED");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      next_valid = req_bus.valid;
      if (req_taken) begin
        req_taken = 1'b0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          drv_item = pending_reqs.pop_front();
          req_bus.func <= drv_item.func;
          req_bus.bus_address <= drv_item.addr;
          req_bus.write_data <= drv_item.wdata;
          req_bus.cycle_amount <= drv_item.amount;
          next_valid = 1'b1;
          if (drv_calm > 0) begin
            drv_calm--;
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, 1) ? 0 : idle_len();
            if ($urandom_range(0, 49) == 0) drv_calm = $urandom_range(20, 120);
          end
        end
      end
      req_bus.valid <= next_valid;
    end
  end

  // response backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (rcv_stall > 0) begin
        rcv_stall--;
        rsp_bus.ready <= 1'b0;
      end else if (rcv_calm > 0) begin
        rcv_calm--;
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b1;
        if ($urandom_range(0, 9) < 3) rcv_stall = idle_len();
        if ($urandom_range(0, 79) == 0) rcv_calm = $urandom_range(20, 150);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        seen_req.func = req_bus.func;
        seen_req.addr = req_bus.bus_address;
        seen_req.wdata = req_bus.write_data;
        seen_req.amount = req_bus.cycle_amount;
        awaited_rsps.push_back(next_timer_response(seen_req));
        taken_reqs++;
        req_taken = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_rsp++;
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected response read_data %02h interrupt_flags %02h",
                   $time, rsp_bus.read_data, rsp_bus.interrupt_flags);
          errors++;
        end else begin
          want_rsp = awaited_rsps.pop_front();
          if (rsp_bus.read_data !== want_rsp.rdata) begin
            $display("%0t: read_data mismatch expected %02h actual %02h",
                     $time, want_rsp.rdata, rsp_bus.read_data);
            errors++;
          end
          if (rsp_bus.interrupt_flags !== want_rsp.flags) begin
            $display("%0t: interrupt_flags mismatch expected %02h actual %02h",
                     $time, want_rsp.flags, rsp_bus.interrupt_flags);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_TICK;
    req_bus.bus_address = '0;
    req_bus.write_data = '0;
    req_bus.cycle_amount = '0;
    rsp_bus.ready = 1'b0;
    div_cnt = '0;
    tima = '0;
    tma = '0;
    tac = '0;
    if_reg = '0;
    irq_pending = '0;
    total_reqs = 0;
    taken_reqs = 0;
    errors = 0;
    n_tick = 0;
    n_read = 0;
    n_write = 0;
    n_wrap = 0;
    n_rsp = 0;
    req_taken = 1'b0;
    send_gap = 0;
    drv_calm = 0;
    rcv_stall = 0;
    rcv_calm = 0;

    // reset values and unmapped reads
    add_req(FUNC_READ, ADDR_DIV, 8'h00, 8'h00);
    add_req(FUNC_READ, ADDR_TIMA, 8'h00, 8'h00);
    add_req(FUNC_READ, ADDR_TMA, 8'h00, 8'h00);
    add_req(FUNC_READ, ADDR_TAC, 8'h00, 8'h00);
    add_req(FUNC_READ, ADDR_IF, 8'h00, 8'h00);
    add_req(FUNC_READ, 16'h0000, 8'hFF, 8'hFF);
    add_req(FUNC_READ, 16'hFFFF, 8'h00, 8'h00);
    // counter wrap with reload and delayed interrupt
    add_req(FUNC_WRITE, ADDR_TAC, 8'h05, 8'h00);
    add_req(FUNC_WRITE, ADDR_TIMA, 8'hFE, 8'h00);
    add_req(FUNC_WRITE, ADDR_TMA, 8'hAB, 8'h00);
    add_req(FUNC_TICK, 16'h0000, 8'h00, 8'hFF);
    add_req(FUNC_TICK, 16'h0000, 8'h00, 8'h01);
    add_req(FUNC_READ, ADDR_IF, 8'h00, 8'h00);
    // divider clear, zero-amount tick, unused func, ignored write
    add_req(FUNC_WRITE, ADDR_DIV, 8'h5A, 8'h00);
    add_req(FUNC_READ, ADDR_DIV, 8'h00, 8'h00);
    add_req(FUNC_TICK, ADDR_TIMA, 8'hFF, 8'h00);
    add_req(FUNC_NONE, ADDR_TIMA, 8'hFF, 8'hFF);
    add_req(FUNC_WRITE, 16'h1234, 8'hFF, 8'h00);
    add_req(FUNC_WRITE, ADDR_IF, 8'hFF, 8'h00);
    add_req(FUNC_READ, ADDR_IF, 8'h00, 8'h00);
    add_req(FUNC_WRITE, ADDR_TAC, 8'hFF, 8'h00);
    add_req(FUNC_READ, ADDR_TAC, 8'h00, 8'h00);
    add_req(FUNC_TICK, 16'h0000, 8'h00, 8'h0A);
    add_req(FUNC_WRITE, ADDR_IF, 8'h00, 8'h00);
    add_req(FUNC_TICK, 16'h0000, 8'h00, 8'h0B);
    repeat (650) add_random_req();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (taken_reqs < total_reqs || awaited_rsps.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("covered %0d ticks, %0d reads, %0d writes, %0d other transactions",
             n_tick, n_read, n_write, total_reqs - n_tick - n_read - n_write);
    $display("timer counter wrapped %0d times, %0d responses checked", n_wrap, n_rsp);
    if (errors == 0 && awaited_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
